// ===== src/assert_macros.svh =====
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// implication checked every clock outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication checked outside reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== src/mlp_pkg.sv =====
// shared types and constants of the two-layer perceptron block
`default_nettype none
package mlp_pkg;
    localparam int MaxInputs  = 1024;
    localparam int MaxHidden  = 128;
    localparam int MaxOutputs = 16;
    localparam int DataWidth  = 16;
    localparam int FracBits   = 12;

    localparam int InW  = $clog2(MaxInputs);
    localparam int HidW = $clog2(MaxHidden);
    localparam int OutW = $clog2(MaxOutputs);
    localparam int W1Aw = InW + HidW;
    localparam int W2Aw = HidW + OutW;
    localparam int BDepth = MaxHidden + MaxOutputs;
    localparam int BAw  = $clog2(BDepth);
    localparam int IdxW = 17;
    localparam int AccW = 48;
    localparam int ProdW = 2 * DataWidth;

    typedef logic signed [DataWidth-1:0] t_data;
    typedef logic [1:0] t_kind;

    localparam t_kind KIND_W1     = 2'd0;
    localparam t_kind KIND_W2     = 2'd1;
    localparam t_kind KIND_BIAS   = 2'd2;
    localparam t_kind KIND_SAMPLE = 2'd3;

    localparam logic [1:0] REG_INPUT_COUNT  = 2'd0;
    localparam logic [1:0] REG_HIDDEN_COUNT = 2'd1;
    localparam logic [1:0] REG_OUTPUT_COUNT = 2'd2;

    typedef struct packed {
        t_kind          kind;
        logic [IdxW-1:0] index;
        t_data          value;
        logic           last;
    } t_in_item;

    typedef struct packed {
        logic [3:0] out_index;
        t_data      out_value;
        logic       out_last;
    } t_out_item;

    // controller to datapath commands
    typedef struct packed {
        logic            load;      // write the input item into its store
        logic            acc_clr;   // load accumulator with bias
        logic            mac;       // issue a memory read pair for one product
        logic            layer2;    // 0 hidden layer, 1 output layer
        logic [HidW:0]   unit;      // hidden or output unit
        logic [InW:0]    elem;      // element within the row
        logic            fin;       // rescale accumulator and retire the unit
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic idle_pipe;  // no product in flight
    } t_stat;

    // rescale q24.24 sum to q4.12 with round-to-nearest and saturation
    function automatic t_data rescale_sat(input logic signed [AccW-1:0] acc);
        logic signed [AccW-1:0] x;
        logic signed [AccW-FracBits-1:0] q;
        x = acc + AccW'(1 << (FracBits - 1));
        q = x[AccW-1:FracBits];
        if (q > (AccW-FracBits)'(2 ** (DataWidth - 1) - 1))
            return t_data'(2 ** (DataWidth - 1) - 1);
        else if (q < -(AccW-FracBits)'(2 ** (DataWidth - 1)))
            return t_data'(-(2 ** (DataWidth - 1)));
        else
            return q[DataWidth-1:0];
    endfunction
endpackage
`default_nettype wire

// ===== src/mlp_stream_if.sv =====
// valid/ready channel carrying one payload type
`default_nettype none
interface mlp_in_if;
    logic              valid;
    logic              ready;
    mlp_pkg::t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface mlp_out_if;
    logic               valid;
    logic               ready;
    mlp_pkg::t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== src/two_layer_mlp_inference.sv =====
// top level of the two-layer perceptron inference block
// usage:
//  - i_in carries requests of four kinds: first-layer weight, second-layer
//    weight, bias and sample element
//  - a sample element marked last starts an inference; i_in stays not ready
//    until every output of that inference has been delivered
//  - o_out delivers output_count results in order, the final one flagged
//  - the single multiply-accumulate unit does one product per cycle while a
//    row is being summed, pausing for pipeline drain once between the layers
//    and for pipeline drain and handoff after each output row; the output row
//    loop waits for each result to be taken
//  - a stalled receiver holds the result register and pauses the sequencer
//  - configuration writes on i_cfg_we set the three counts from the low 11, 8
//    and 5 bits of i_cfg_data, zero acting as one and excess as the maximum
//  - synchronous reset clears biases to zero through valid bits and returns
//    the counts to 784, 128 and 10; weights and samples need writing first
`default_nettype none
module two_layer_mlp_inference (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    mlp_in_if.sink     i_in,
    mlp_out_if.source  o_out,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [10:0] i_cfg_data
);
    logic [10:0] r_input_count;
    logic [7:0]  r_hidden_count;
    logic [4:0]  r_output_count;
    logic [mlp_pkg::InW:0]  ni;
    logic [mlp_pkg::HidW:0] nh;
    logic [mlp_pkg::OutW:0] no;
    mlp_pkg::t_cmd  cmd;
    mlp_pkg::t_stat stat;
    logic out_last;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_input_count  <= 11'd784;
            r_hidden_count <= 8'd128;
            r_output_count <= 5'd10;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                mlp_pkg::REG_INPUT_COUNT:  r_input_count  <= i_cfg_data;
                mlp_pkg::REG_HIDDEN_COUNT: r_hidden_count <= i_cfg_data[7:0];
                mlp_pkg::REG_OUTPUT_COUNT: r_output_count <= i_cfg_data[4:0];
                default: ;
            endcase
        end
    end

    // clamp counts into range
    always_comb begin
        if (r_input_count == '0) ni = (mlp_pkg::InW+1)'(1);
        else if (r_input_count > 11'(mlp_pkg::MaxInputs))
            ni = (mlp_pkg::InW+1)'(mlp_pkg::MaxInputs);
        else ni = r_input_count[mlp_pkg::InW:0];
        if (r_hidden_count == '0) nh = (mlp_pkg::HidW+1)'(1);
        else if (r_hidden_count > 8'(mlp_pkg::MaxHidden))
            nh = (mlp_pkg::HidW+1)'(mlp_pkg::MaxHidden);
        else nh = r_hidden_count[mlp_pkg::HidW:0];
        if (r_output_count == '0) no = (mlp_pkg::OutW+1)'(1);
        else if (r_output_count > 5'(mlp_pkg::MaxOutputs))
            no = (mlp_pkg::OutW+1)'(mlp_pkg::MaxOutputs);
        else no = r_output_count[mlp_pkg::OutW:0];
    end

    mlp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_item      (i_in.data),
        .o_in_ready  (i_in.ready),
        .i_ni        (ni),
        .i_nh        (nh),
        .i_no        (no),
        .i_stat      (stat),
        .i_res_valid (o_out.valid),
        .i_res_ready (o_out.ready),
        .o_cmd       (cmd),
        .o_out_last  (out_last)
    );

    mlp_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_item      (i_in.data),
        .i_ni        (ni),
        .i_nh        (nh),
        .i_out_last  (out_last && (cmd.unit + 1'b1 == (mlp_pkg::HidW+1)'(no))),
        .i_res_ready (o_out.ready),
        .o_stat      (stat),
        .o_res_valid (o_out.valid),
        .o_res       (o_out.data)
    );
endmodule
`default_nettype wire

// ===== src/mlp_datapath.sv =====
// stores, multiply-accumulate unit and output register
`default_nettype none
`include "assert_macros.svh"
module mlp_datapath (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire mlp_pkg::t_cmd i_cmd,
    input  wire mlp_pkg::t_in_item i_item,
    input  wire logic [mlp_pkg::InW:0]  i_ni,
    input  wire logic [mlp_pkg::HidW:0] i_nh,
    input  wire logic          i_out_last,
    input  wire logic          i_res_ready,
    output mlp_pkg::t_stat     o_stat,
    output logic               o_res_valid,
    output mlp_pkg::t_out_item o_res
);
    localparam int W1D = mlp_pkg::MaxInputs * mlp_pkg::MaxHidden;
    localparam int W2D = mlp_pkg::MaxHidden * mlp_pkg::MaxOutputs;

    mlp_pkg::t_data w1_mem [W1D];
    mlp_pkg::t_data w2_mem [W2D];
    mlp_pkg::t_data s_mem  [mlp_pkg::MaxInputs];
    mlp_pkg::t_data h_mem  [mlp_pkg::MaxHidden];
    mlp_pkg::t_data b_mem  [mlp_pkg::BDepth];
    logic [mlp_pkg::BDepth-1:0] r_b_vld;

    logic [mlp_pkg::W1Aw-1:0] w1_raddr;
    logic [mlp_pkg::W2Aw-1:0] w2_raddr;
    logic [mlp_pkg::BAw-1:0]  b_raddr;
    logic [mlp_pkg::W1Aw+1:0] w1_prod;
    logic [mlp_pkg::W2Aw+1:0] w2_prod;
    logic [mlp_pkg::BAw:0]    b_sum;

    mlp_pkg::t_data r_opa, r_opb, r_bias;
    logic r_rd_vld, r_rd_clr, r_rd_fin, r_rd_l2, r_rd_bv;
    logic [mlp_pkg::HidW:0] r_rd_unit;
    logic signed [mlp_pkg::ProdW-1:0] r_prod;
    logic r_p_vld, r_p_clr, r_p_fin, r_p_l2, r_p_bv;
    logic [mlp_pkg::HidW:0] r_p_unit;
    mlp_pkg::t_data r_p_bias;
    logic signed [mlp_pkg::AccW-1:0] r_acc, acc_base, acc_new;
    logic r_fin, r_fin_l2;
    logic [mlp_pkg::HidW:0] r_fin_unit;
    mlp_pkg::t_data fin_q;

    logic ld_w1, ld_w2, ld_b, ld_s;

    // load decode with range checks
    always_comb begin
        ld_w1 = i_cmd.load && i_item.kind == mlp_pkg::KIND_W1 &&
                {1'b0, i_item.index} < (mlp_pkg::IdxW+1)'(W1D);
        ld_w2 = i_cmd.load && i_item.kind == mlp_pkg::KIND_W2 &&
                i_item.index < mlp_pkg::IdxW'(W2D);
        ld_b  = i_cmd.load && i_item.kind == mlp_pkg::KIND_BIAS &&
                i_item.index < mlp_pkg::IdxW'(mlp_pkg::BDepth);
        ld_s  = i_cmd.load && i_item.kind == mlp_pkg::KIND_SAMPLE &&
                i_item.index < mlp_pkg::IdxW'(mlp_pkg::MaxInputs);
    end

    // row address generation: unit * count + element; bias address is the unit, offset by the hidden count in layer two
    always_comb begin
        w1_prod  = (mlp_pkg::W1Aw+2)'(i_cmd.unit) * (mlp_pkg::W1Aw+2)'(i_ni)
                   + (mlp_pkg::W1Aw+2)'(i_cmd.elem);
        w2_prod  = (mlp_pkg::W2Aw+2)'(i_cmd.unit) * (mlp_pkg::W2Aw+2)'(i_nh)
                   + (mlp_pkg::W2Aw+2)'(i_cmd.elem);
        w1_raddr = w1_prod[mlp_pkg::W1Aw-1:0];
        w2_raddr = w2_prod[mlp_pkg::W2Aw-1:0];
        b_sum    = i_cmd.layer2 ? (mlp_pkg::BAw+1)'(i_cmd.unit) + (mlp_pkg::BAw+1)'(i_nh)
                                : (mlp_pkg::BAw+1)'(i_cmd.unit);
        b_raddr  = b_sum[mlp_pkg::BAw-1:0];
    end

    // store writes and registered reads
    always_ff @(posedge i_clk) begin
        if (ld_w1) w1_mem[i_item.index[mlp_pkg::W1Aw-1:0]] <= i_item.value;
        if (ld_w2) w2_mem[i_item.index[mlp_pkg::W2Aw-1:0]] <= i_item.value;
        if (ld_s)  s_mem[i_item.index[mlp_pkg::InW-1:0]] <= i_item.value;
        if (ld_b)  b_mem[i_item.index[mlp_pkg::BAw-1:0]] <= i_item.value;
        if (r_fin && !r_fin_l2)
            h_mem[r_fin_unit[mlp_pkg::HidW-1:0]] <= fin_q[mlp_pkg::DataWidth-1] ? '0 : fin_q;
        if (i_cmd.mac) begin
            if (i_cmd.layer2) begin
                r_opa <= h_mem[i_cmd.elem[mlp_pkg::HidW-1:0]];
                r_opb <= w2_mem[w2_raddr];
            end else begin
                r_opa <= s_mem[i_cmd.elem[mlp_pkg::InW-1:0]];
                r_opb <= w1_mem[w1_raddr];
            end
            r_bias <= b_mem[b_raddr];
        end
        r_rd_unit <= i_cmd.unit;
        r_rd_clr  <= i_cmd.acc_clr;
        r_rd_fin  <= i_cmd.fin;
        r_rd_l2   <= i_cmd.layer2;
        r_rd_bv   <= r_b_vld[b_raddr];
        r_prod    <= r_opa * r_opb;
        r_p_clr   <= r_rd_clr;
        r_p_fin   <= r_rd_fin;
        r_p_l2    <= r_rd_l2;
        r_p_bv    <= r_rd_bv;
        r_p_unit  <= r_rd_unit;
        r_p_bias  <= r_bias;
        r_fin_unit <= r_p_unit;
        r_fin_l2   <= r_p_l2;
    end

    // bias valid bits, cleared by reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= '0;
        end else if (ld_b) begin
            r_b_vld[i_item.index[mlp_pkg::BAw-1:0]] <= 1'b1;
        end
    end

    // accumulate: first product of a row starts from the shifted bias
    always_comb begin
        acc_base = r_p_clr
            ? (r_p_bv ? (mlp_pkg::AccW'(r_p_bias) <<< mlp_pkg::FracBits) : '0)
            : r_acc;
        acc_new  = acc_base + mlp_pkg::AccW'(r_prod);
        fin_q    = mlp_pkg::rescale_sat(r_acc);
    end

    // pipeline control and accumulator; result valid holds until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld    <= 1'b0;
            r_p_vld     <= 1'b0;
            r_fin       <= 1'b0;
            o_res_valid <= 1'b0;
        end else begin
            r_rd_vld    <= i_cmd.mac;
            r_p_vld     <= r_rd_vld;
            r_fin       <= r_p_vld && r_p_fin;
            if (r_fin && r_fin_l2) begin
                o_res_valid <= 1'b1;
            end else if (i_res_ready) begin
                o_res_valid <= 1'b0;
            end
            if (r_p_vld) r_acc <= acc_new;
        end
    end

    // output result register
    always_ff @(posedge i_clk) begin
        if (r_fin && r_fin_l2) begin
            o_res.out_index <= r_fin_unit[3:0];
            o_res.out_value <= fin_q;
            o_res.out_last  <= i_out_last;
        end
    end

    assign o_stat.idle_pipe = !r_rd_vld && !r_p_vld && !r_fin;

    `ASSERT_NEXT(a_pipe_adv, i_clk, i_rst_n, i_cmd.mac, r_rd_vld)
    `ASSERT_NEXT(a_fin_follows, i_clk, i_rst_n, r_p_vld && r_p_fin, r_fin)
    `ASSERT_IMPL(a_no_load_busy, i_clk, i_rst_n, i_cmd.load, !i_cmd.mac)
endmodule
`default_nettype wire

// ===== src/mlp_ctrl.sv =====
// sequencer over hidden and output rows
`default_nettype none
`include "assert_macros.svh"
module mlp_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire mlp_pkg::t_in_item i_item,
    output logic                   o_in_ready,
    input  wire logic [mlp_pkg::InW:0]  i_ni,
    input  wire logic [mlp_pkg::HidW:0] i_nh,
    input  wire logic [mlp_pkg::OutW:0] i_no,
    input  wire mlp_pkg::t_stat    i_stat,
    input  wire logic              i_res_valid,
    input  wire logic              i_res_ready,
    output mlp_pkg::t_cmd          o_cmd,
    output logic                   o_out_last
);
    typedef enum logic [2:0] {S_LOAD, S_L1, S_DRAIN1, S_L2, S_WAIT_OUT} t_state;
    t_state r_state;
    logic [mlp_pkg::HidW:0] r_unit;
    logic [mlp_pkg::InW:0]  r_elem;
    logic row_end, unit_end, start;

    assign start      = o_in_ready && i_in_valid && i_item.kind == mlp_pkg::KIND_SAMPLE &&
                        i_item.last;
    assign o_in_ready = (r_state == S_LOAD);
    assign row_end    = (r_state == S_L1) ? (r_elem + 1'b1 == i_ni)
                                          : (r_elem[mlp_pkg::HidW:0] + 1'b1 == i_nh);
    assign unit_end   = (r_state == S_L1) ? (r_unit + 1'b1 == i_nh)
                                          : (r_unit + 1'b1 == (mlp_pkg::HidW+1)'(i_no));

    // command assembly
    always_comb begin
        o_cmd.load    = o_in_ready && i_in_valid;
        o_cmd.mac     = (r_state == S_L1) || (r_state == S_L2);
        o_cmd.layer2  = (r_state == S_L2);
        o_cmd.unit    = r_unit;
        o_cmd.elem    = r_elem;
        o_cmd.acc_clr = (r_elem == '0);
        o_cmd.fin     = o_cmd.mac && row_end;
        o_out_last    = (r_state == S_WAIT_OUT);
    end

    // state and counters; one output unit in flight at a time in layer two
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_unit  <= '0;
            r_elem  <= '0;
        end else begin
            unique case (r_state)
                S_LOAD: begin
                    r_unit <= '0;
                    r_elem <= '0;
                    if (start) r_state <= S_L1;
                end
                S_L1: begin
                    if (row_end) begin
                        r_elem <= '0;
                        r_unit <= r_unit + 1'b1;
                        if (unit_end) r_state <= S_DRAIN1;
                    end else begin
                        r_elem <= r_elem + 1'b1;
                    end
                end
                S_DRAIN1: begin
                    r_unit <= '0;
                    if (i_stat.idle_pipe) r_state <= S_L2;
                end
                S_L2: begin
                    if (row_end) begin
                        r_elem  <= '0;
                        r_state <= S_WAIT_OUT;
                    end else begin
                        r_elem <= r_elem + 1'b1;
                    end
                end
                S_WAIT_OUT: begin
                    if (i_res_valid && i_res_ready) begin
                        r_unit <= r_unit + 1'b1;
                        if (r_unit + 1'b1 == (mlp_pkg::HidW+1)'(i_no)) r_state <= S_LOAD;
                        else r_state <= S_L2;
                    end
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end

    `ASSERT_IMPL(a_no_mac_in_load, i_clk, i_rst_n, o_in_ready, !o_cmd.mac)
    `ASSERT_IMPL(a_res_only_wait, i_clk, i_rst_n, i_res_valid, r_state == S_WAIT_OUT)
    `ASSERT_NEXT(a_start_l1, i_clk, i_rst_n, start, r_state == S_L1)
endmodule
`default_nettype wire

// ===== tb/two_layer_mlp_inference_tb.sv =====
// self-checking testbench of the two-layer perceptron inference block
`default_nettype none
module two_layer_mlp_inference_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import mlp_pkg::*;

    localparam int CycleLimit = 1_000_000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [1:0] cfg_idx = '0;
    logic [10:0] cfg_data = '0;

    mlp_in_if in_ch();
    mlp_out_if out_ch();

    two_layer_mlp_inference DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in(in_ch),
        .o_out(out_ch),
        .i_cfg_we(cfg_we),
        .i_cfg_idx(cfg_idx),
        .i_cfg_data(cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // model of the stores and the counts in use
    t_data w1_mem [0:MaxInputs*MaxHidden-1];
    t_data w2_mem [0:MaxHidden*MaxOutputs-1];
    t_data bias_mem [0:BDepth-1];
    t_data sample_mem [0:MaxInputs-1];
    t_data hidden_mem [0:MaxHidden-1];
    int n_in, n_hid, n_out;

    t_out_item pending_outputs[$];
    int errors = 0;
    int outputs_seen = 0;
    bit idle_on = 1'b1;
    longint cycles = 0;

    function automatic int clamp_count(int c, int hi);
        if (c == 0) return 1;
        return (c > hi) ? hi : c;
    endfunction

    function automatic t_data round_saturate(longint acc);
        longint q;
        q = (acc + 2048) >>> FracBits;
        if (q > 32767) q = 32767;
        if (q < -32768) q = -32768;
        return t_data'(q);
    endfunction

    // apply one accepted request to the model, returning the outputs it causes
    function automatic void apply_request(t_in_item it, ref t_out_item res[$]);
        longint acc;
        t_data h;
        t_out_item o;
        res.delete();
        case (it.kind)
            KIND_W1: w1_mem[it.index] = it.value;
            KIND_W2: if (it.index < MaxHidden*MaxOutputs) w2_mem[it.index] = it.value;
            KIND_BIAS: if (it.index < BDepth) bias_mem[it.index] = it.value;
            default: begin
                if (it.index < MaxInputs) sample_mem[it.index] = it.value;
                if (it.last) begin
                    for (int i = 0; i < n_hid; i++) begin
                        acc = longint'(bias_mem[i]) * 4096;
                        for (int j = 0; j < n_in; j++)
                            acc += longint'(sample_mem[j]) * longint'(w1_mem[i*n_in+j]);
                        h = round_saturate(acc);
                        hidden_mem[i] = (h < 0) ? t_data'(0) : h;
                    end
                    for (int i = 0; i < n_out; i++) begin
                        acc = longint'(bias_mem[n_hid+i]) * 4096;
                        for (int j = 0; j < n_hid; j++)
                            acc += longint'(hidden_mem[j]) * longint'(w2_mem[i*n_hid+j]);
                        o.out_index = i[3:0];
                        o.out_value = round_saturate(acc);
                        o.out_last = (i + 1 == n_out);
                        res = {res, o};
                    end
                end
            end
        endcase
    endfunction

    // offer one request; typed expectations replace the model's outputs
    task automatic send_request(t_in_item it, bit typed = 0, t_data typed_val = '0);
        int gap;
        t_out_item res[$];
        t_out_item o;
        gap = idle_on ? $urandom_range(0, 15) : 0;
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data <= it;
        // ready only changes at the rising edge, so look at it mid-cycle
        @(negedge i_clk);
        while (!in_ch.ready) @(negedge i_clk);
        @(posedge i_clk);
        apply_request(it, res);
        if (typed && res.size() > 0) begin
            o.out_index = '0;
            o.out_value = typed_val;
            o.out_last = 1'b1;
            pending_outputs = {pending_outputs, o};
        end else begin
            foreach (res[k]) pending_outputs = {pending_outputs, res[k]};
        end
    endtask

    // let the block drain before touching the counts
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (pending_outputs.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic set_counts(int raw_in, int raw_hid, int raw_out);
        cfg_we <= 1'b1; cfg_idx <= REG_INPUT_COUNT; cfg_data <= 11'(raw_in);
        @(posedge i_clk);
        cfg_we <= 1'b1; cfg_idx <= REG_HIDDEN_COUNT; cfg_data <= 11'(raw_hid & 8'hff);
        @(posedge i_clk);
        cfg_we <= 1'b1; cfg_idx <= REG_OUTPUT_COUNT; cfg_data <= 11'(raw_out & 5'h1f);
        @(posedge i_clk);
        cfg_we <= 1'b0;
        n_in = clamp_count(raw_in & 11'h7ff, MaxInputs);
        n_hid = clamp_count(raw_hid & 8'hff, MaxHidden);
        n_out = clamp_count(raw_out & 5'h1f, MaxOutputs);
    endtask

    function automatic t_data pick_value();
        if ($urandom_range(0, 2) == 0) return t_data'($urandom);
        return t_data'(int'($urandom_range(0, 2047)) - 1024);
    endfunction

    function automatic t_in_item make_req(t_kind k, int idx, t_data v, bit l);
        t_in_item it;
        it.kind = k;
        it.index = idx[IdxW-1:0];
        it.value = v;
        it.last = l;
        return it;
    endfunction

    // fill every weight and sample entry that the current counts read
    task automatic load_network();
        for (int a = 0; a < n_in*n_hid; a++)
            send_request(make_req(KIND_W1, a, pick_value(), $urandom_range(0, 1)));
        for (int a = 0; a < n_hid*n_out; a++)
            send_request(make_req(KIND_W2, a, pick_value(), $urandom_range(0, 1)));
        for (int a = 0; a < n_in; a++)
            send_request(make_req(KIND_SAMPLE, a, pick_value(), 1'b0));
    endtask

    // random mix: mostly loads and samples, with inference starts among them
    task automatic random_traffic(int n_req);
        int r;
        int idx;
        t_in_item it;
        for (int k = 0; k < n_req; k++) begin
            r = $urandom_range(0, 99);
            if (r < 10)
                it = make_req(KIND_W1, $urandom_range(0, n_in*n_hid-1), pick_value(),
                              $urandom_range(0, 1));
            else if (r < 15)
                it = make_req(KIND_W1, $urandom_range(0, 131071), pick_value(), 1'b0);
            else if (r < 25) begin
                idx = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 131071)
                                                   : $urandom_range(0, n_hid*n_out-1);
                it = make_req(KIND_W2, idx, pick_value(), $urandom_range(0, 1));
            end else if (r < 40) begin
                idx = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 131071)
                                                   : $urandom_range(0, n_hid+n_out-1);
                it = make_req(KIND_BIAS, idx, pick_value(), $urandom_range(0, 1));
            end else if (r < 70)
                it = make_req(KIND_SAMPLE, $urandom_range(0, n_in-1), pick_value(), 1'b0);
            else begin
                idx = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 131071)
                                                   : $urandom_range(0, n_in-1);
                it = make_req(KIND_SAMPLE, idx, pick_value(), 1'b1);
            end
            send_request(it);
        end
    endtask

    typedef struct {
        t_in_item req;
        bit       typed;
        t_data    val;
    } t_row;

    // directed rows with counts all set to one
    t_row rows[] = '{
        '{'{KIND_W1, 17'd0, 16'sh1000, 1'b0}, 1'b0, 16'sh0},
        '{'{KIND_W2, 17'd0, 16'sh1000, 1'b0}, 1'b0, 16'sh0},
        '{'{KIND_SAMPLE, 17'd0, 16'sh1000, 1'b1}, 1'b1, 16'sh1000},
        '{'{KIND_W1, 17'd0, 16'sh7fff, 1'b1}, 1'b0, 16'sh0},
        '{'{KIND_SAMPLE, 17'd0, 16'sh7fff, 1'b1}, 1'b1, 16'sh7fff},
        '{'{KIND_W2, 17'd0, 16'sh7fff, 1'b0}, 1'b0, 16'sh0},
        '{'{KIND_SAMPLE, 17'd0, 16'sh7fff, 1'b1}, 1'b1, 16'sh7fff},
        '{'{KIND_W1, 17'd0, 16'sh8000, 1'b0}, 1'b0, 16'sh0},
        '{'{KIND_SAMPLE, 17'd0, 16'sh7fff, 1'b1}, 1'b1, 16'sh0},
        '{'{KIND_BIAS, 17'd1, 16'sh8000, 1'b1}, 1'b0, 16'sh0},
        '{'{KIND_SAMPLE, 17'd1024, 16'sh0000, 1'b1}, 1'b1, 16'sh8000},
        '{'{KIND_BIAS, 17'd144, 16'sh1234, 1'b0}, 1'b0, 16'sh0},
        '{'{KIND_W2, 17'd2048, 16'sh5555, 1'b0}, 1'b0, 16'sh0},
        '{'{KIND_W1, 17'h1ffff, 16'shaaaa, 1'b0}, 1'b0, 16'sh0},
        '{'{KIND_SAMPLE, 17'h1ffff, 16'sh0000, 1'b1}, 1'b1, 16'sh8000},
        '{'{KIND_BIAS, 17'd0, 16'sh7fff, 1'b0}, 1'b0, 16'sh0},
        '{'{KIND_SAMPLE, 17'd0, 16'sh8000, 1'b1}, 1'b0, 16'sh0},
        '{'{KIND_SAMPLE, 17'd0, 16'sh0800, 1'b0}, 1'b0, 16'sh0},
        '{'{KIND_BIAS, 17'd1, 16'sh0123, 1'b0}, 1'b0, 16'sh0},
        '{'{KIND_SAMPLE, 17'd0, 16'shf000, 1'b1}, 1'b0, 16'sh0}
    };

    // stimulus
    initial begin
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        foreach (bias_mem[k]) bias_mem[k] = '0;
        n_in = 784; n_hid = 128; n_out = 10;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        set_counts(1, 1, 1);
        foreach (rows[k]) send_request(rows[k].req, rows[k].typed, rows[k].val);

        wait_drained();
        set_counts(3, 4, 3);
        load_network();
        random_traffic(25);

        // zero counts behave as one
        wait_drained();
        set_counts(0, 0, 0);
        random_traffic(10);

        // output count above its maximum is capped
        wait_drained();
        set_counts(2, 1, 31);
        load_network();
        random_traffic(15);

        wait_drained();
        idle_on = 1'b0;
        set_counts(5, 2, 4);
        load_network();
        random_traffic(25);

        in_ch.valid <= 1'b0;
        while (pending_outputs.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (errors == 0) begin
            $display("two_layer_mlp_inference test passed");
        end else begin
            $display("two_layer_mlp_inference test failed");
        end
        $finish;
    end

    // result side: random stalls, one long hold-off, field checks
    initial begin
        int gap;
        bit held;
        t_out_item want;
        t_out_item got;
        held = 1'b0;
        out_ch.ready = 1'b0;
        wait (i_rst_n);
        forever begin
            gap = idle_on ? $urandom_range(0, 15) : 0;
            if (!held && outputs_seen >= 9) begin
                held = 1'b1;
                gap = 600;
            end
            if (gap > 0) begin
                out_ch.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            // valid and data are registered, so sample them mid-cycle
            @(negedge i_clk);
            while (!out_ch.valid) @(negedge i_clk);
            got = out_ch.data;
            @(posedge i_clk);
            outputs_seen++;
            if (pending_outputs.size() == 0) begin
                errors++;
                $display("%0t: unexpected output index %0d value %0d last %0b", $time,
                         got.out_index, got.out_value, got.out_last);
            end else begin
                want = pending_outputs.pop_front();
                if (got.out_index !== want.out_index) begin
                    errors++;
                    $display("%0t: out_index expected %0d actual %0d", $time,
                             want.out_index, got.out_index);
                end
                if (got.out_value !== want.out_value) begin
                    errors++;
                    $display("%0t: out_value expected %0d actual %0d", $time,
                             want.out_value, got.out_value);
                end
                if (got.out_last !== want.out_last) begin
                    errors++;
                    $display("%0t: out_last expected %0b actual %0b", $time,
                             want.out_last, got.out_last);
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("two_layer_mlp_inference test failed");
            $finish;
        end
    end
endmodule
`default_nettype wire

// ===== two_layer_mlp_inference.f =====
+incdir+src
src/mlp_pkg.sv
src/mlp_stream_if.sv
src/mlp_datapath.sv
src/mlp_ctrl.sv
src/two_layer_mlp_inference.sv
tb/two_layer_mlp_inference_tb.sv
